>>> rtl/core/sidf_pkg.sv
// ---------------------------------------------------------------------------
// sidf_pkg
// Shared constants and types for the duplicate message filter.
// ---------------------------------------------------------------------------
package sidf_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int ID_W    = 40;
	localparam int STAMP_W = 32;
	localparam int SLOT_W  = 8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic               active;
		logic               hit;
		logic               free_found;
		logic [STAMP_W-1:0] best;
		logic [IDX_W-1:0]   chosen;
	} scan_t;

	typedef struct packed {
		logic               en;
		logic [IDX_W-1:0]   idx;
		logic [ID_W-1:0]    id;
		logic [STAMP_W-1:0] stamp;
	} wr_t;

endpackage

>>> rtl/core/sidf_req_if.sv
// ---------------------------------------------------------------------------
// sidf_req_if
// Request channel carrying a message id and the current time.
// ---------------------------------------------------------------------------
interface sidf_req_if import sidf_pkg::*;;
	logic               valid;
	logic               ready;
	logic [ID_W-1:0]    message_id;
	logic [STAMP_W-1:0] current_time;

	modport source (output valid, output message_id, output current_time, input ready);
	modport sink (input valid, input message_id, input current_time, output ready);
endinterface

>>> rtl/core/sidf_rsp_if.sv
// ---------------------------------------------------------------------------
// sidf_rsp_if
// Response channel carrying the duplicate flag and the slot written.
// ---------------------------------------------------------------------------
interface sidf_rsp_if import sidf_pkg::*;;
	logic              valid;
	logic              ready;
	logic              was_seen;
	logic [SLOT_W-1:0] slot_used;

	modport source (output valid, output was_seen, output slot_used, input ready);
	modport sink (input valid, input was_seen, input slot_used, output ready);
endinterface

>>> rtl/core/sidf_cfg_if.sv
// ---------------------------------------------------------------------------
// sidf_cfg_if
// Configuration write channel for the end time limit register.
// ---------------------------------------------------------------------------
interface sidf_cfg_if import sidf_pkg::*;;
	logic               valid;
	logic               ready;
	logic [STAMP_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/sidf_cell.sv
// ---------------------------------------------------------------------------
// sidf_cell
// One cache entry; updates the passing scan token and forwards it.
// ---------------------------------------------------------------------------
module sidf_cell import sidf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] idx,
	input  logic [ID_W-1:0]  key,
	input  scan_t            tok_in,
	output scan_t            tok_out,
	input  wr_t              wr
);

	logic               valid_q;
	logic [ID_W-1:0]    id_q;
	logic [STAMP_W-1:0] stamp_q;
	scan_t              tok_q;
	scan_t              tok_nxt;
	logic               wr_hit;

	assign wr_hit = wr.en && (wr.idx == idx);

	always_comb begin
		tok_nxt = tok_in;
		if (tok_in.active) begin
			if (valid_q && (id_q == key)) begin
				tok_nxt.hit = 1'b1;
			end
			if (!tok_in.free_found) begin
				if (stamp_q == '0) begin
					tok_nxt.free_found = 1'b1;
					tok_nxt.chosen     = idx;
				end else if (stamp_q < tok_in.best) begin
					tok_nxt.best   = stamp_q;
					tok_nxt.chosen = idx;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= '0;
			valid_q <= 1'b0;
			stamp_q <= '0;
		end else begin
			tok_q <= tok_nxt;
			if (wr_hit) begin
				valid_q <= 1'b1;
				stamp_q <= wr.stamp;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			id_q <= wr.id;
		end
	end

	assign tok_out = tok_q;

endmodule

>>> rtl/core/seen_id_filter_oldest_replace.sv
// ---------------------------------------------------------------------------
// seen_id_filter_oldest_replace
// Duplicate message filter over a small cache with oldest-entry replacement.
// ---------------------------------------------------------------------------
// Each request on req carries a message id and the current time. The block
// answers on rsp with was_seen set if the id is held by a valid entry, and
// otherwise stores the id and time and reports the slot it wrote. The slot
// is the first free entry (time zero), else the entry with the smallest
// time below the end time limit, else slot 0.
// The lookup is a token that walks a row of ENTRIES cells, one cell per
// cycle, and one request is handled at a time.
// A finished result waits in the output register while the receiver stalls;
// a new request is taken as soon as the cache update has been made.
// The cfg channel writes the end time limit and is always ready.
// Reset clears all entries to invalid and free and sets the limit to all ones.
// ---------------------------------------------------------------------------
module seen_id_filter_oldest_replace import sidf_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	sidf_req_if.sink  req,
	sidf_rsp_if.source rsp,
	sidf_cfg_if.sink  cfg
);

	state_t             state_q;
	state_t             state_nxt;
	logic [ID_W-1:0]    key_q;
	logic [STAMP_W-1:0] now_q;
	logic [STAMP_W-1:0] limit_q;
	logic               start_q;
	scan_t              dec_q;
	logic               rsp_vld_q;
	logic               rsp_seen_q;
	logic [SLOT_W-1:0]  rsp_slot_q;
	logic               req_acc;
	logic               out_free;
	logic               emit;
	scan_t              tok [ENTRIES+1];
	logic [ENTRIES-1:0] tok_act;
	wr_t                wr;

	assign req_acc  = req.valid && req.ready;
	assign out_free = !rsp_vld_q || rsp.ready;
	assign emit     = (state_q == ST_DONE) && out_free;

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	assign tok[0] = {start_q, 1'b0, 1'b0, limit_q, {IDX_W{1'b0}}};

	for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
		sidf_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (IDX_W'(k)),
			.key     (key_q),
			.tok_in  (tok[k]),
			.tok_out (tok[k+1]),
			.wr      (wr)
		);
		assign tok_act[k] = tok[k+1].active;
	end

	always_comb begin
		wr.en    = emit && !dec_q.hit;
		wr.idx   = dec_q.chosen;
		wr.id    = key_q;
		wr.stamp = now_q;
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (tok[ENTRIES].active) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			start_q   <= 1'b0;
			limit_q   <= '1;
			rsp_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			start_q <= req_acc;
			if (cfg.valid && cfg.ready) begin
				limit_q <= cfg.data;
			end
			if (emit) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			key_q <= req.message_id;
			now_q <= req.current_time;
		end
		if ((state_q == ST_SCAN) && tok[ENTRIES].active) begin
			dec_q <= tok[ENTRIES];
		end
		if (emit) begin
			rsp_seen_q <= dec_q.hit;
			rsp_slot_q <= dec_q.hit ? '0 : SLOT_W'(dec_q.chosen);
		end
	end

	assign rsp.valid     = rsp_vld_q;
	assign rsp.was_seen  = rsp_seen_q;
	assign rsp.slot_used = rsp_slot_q;

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({start_q, tok_act}))
		else $error("more than one scan token in the cell row");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!start_q && (tok_act == '0)))
		else $error("scan token present while idle");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_vld_q) |-> $past(state_q == ST_DONE))
		else $error("response raised outside the done state");

	a_hit_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_vld_q && rsp_seen_q) |-> (rsp_slot_q == '0))
		else $error("duplicate reported with a nonzero slot");

endmodule
